// ----- rtl/lru_key_value_cache_macros.svh -----
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// expression must hold at every clock edge outside reset
`define LKV_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LKV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, action codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CNT_BITS   = 32;
   localparam int CAP_BITS   = 5;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   typedef enum logic [1:0] {
      ACT_GET   = 2'd0,
      ACT_PUT   = 2'd1,
      ACT_ERASE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // per-cell move control: load from the more recent neighbor, from the
   // less recent neighbor, or hold; plus the next valid bit
   typedef struct packed {
      logic take_prev;
      logic take_next;
      logic valid_in;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative store kept as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low, one
// request per cycle; its result appears on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, in the cycle right after. The receiver cannot
// stall the result. All sixteen cells compare the key in parallel and shift
// at the edge that takes the request. busy is high in reset and in the cycle
// after it. A capacity write lowers occupancy at its own edge, dropping the
// oldest entries and counting them as evictions.
`default_nettype none

`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache
   import lkv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [1:0]            req_action,
   input  wire logic [KEY_BITS-1:0]   req_key,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_strobe,
   output logic                       rsp_hit,
   output logic [VALUE_BITS-1:0]      rsp_read_value,
   output logic [CAP_BITS-1:0]        rsp_occupancy,
   output logic [CNT_BITS-1:0]        rsp_hit_count,
   output logic [CNT_BITS-1:0]        rsp_miss_count,
   output logic [CNT_BITS-1:0]        rsp_evict_count,
   input  wire logic                  csr_write_en,
   input  wire logic [CAP_BITS-1:0]   csr_write_data
);

   // saturating add of a small amount
   function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] cnt,
                                                   input logic [OCC_BITS-1:0] amt);
      logic [CNT_BITS:0] sum;
      sum = {1'b0, cnt} + (CNT_BITS + 1)'(amt);
      return sum[CNT_BITS] ? '1 : sum[CNT_BITS-1:0];
   endfunction

   // capacity limited to the number of cells
   function automatic logic [OCC_BITS-1:0] eff_cap(input logic [CAP_BITS-1:0] cap);
      return (OCC_BITS'(cap) > OCC_BITS'(ENTRIES)) ? OCC_BITS'(ENTRIES) : OCC_BITS'(cap);
   endfunction

   localparam logic [OCC_BITS-1:0] ONE = OCC_BITS'(1);

   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_value [ENTRIES];
   logic [ENTRIES-1:0]    cell_valid;
   logic [ENTRIES-1:0]    match_vec;
   logic [ENTRIES-1:0]    at_or_after;   // position at or older than the hit
   logic [ENTRIES-1:0]    up_to_hit;     // position at or newer than the hit
   cell_ctrl_type         cell_ctrl  [ENTRIES];

   logic [ENTRIES-1:0]    take_prev, take_next;
   logic [KEY_BITS-1:0]   front_key;
   logic [VALUE_BITS-1:0] front_value;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  hit_any;
   logic                  accept;
   action_type            action;
   logic [OCC_BITS-1:0]   cap_eff, new_eff;

   logic                  busy_ff;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic [CNT_BITS-1:0]   hits_ff, hits_in;
   logic [CNT_BITS-1:0]   misses_ff, misses_in;
   logic [CNT_BITS-1:0]   evicts_ff, evicts_in;
   logic                  strobe_ff, strobe_in;
   logic                  hit_ff, hit_in;
   logic [VALUE_BITS-1:0] rdval_ff, rdval_in;

   assign busy    = reset | busy_ff;
   assign accept  = start & ~busy;
   assign action  = action_type'(req_action);
   assign cap_eff = eff_cap(cap_ff);
   assign new_eff = eff_cap(csr_write_data);
   assign hit_any = |match_vec;

   // chain of cells, position 0 is most recent
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      assign cell_ctrl[i].take_prev = take_prev[i];
      assign cell_ctrl[i].take_next = take_next[i];
      assign cell_ctrl[i].valid_in  = (OCC_BITS'(i) < occ_in);

      assign at_or_after[i] = |match_vec[i:0];
      if (i == 0) begin : g_head
         assign up_to_hit[i] = 1'b1;
      end else begin : g_body
         assign up_to_hit[i] = ~(|match_vec[i-1:0]);
      end

      if (i == 0 && i == ENTRIES - 1) begin : g_only
         lkv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .lookup_key (req_key),
            .prev_key   (front_key),
            .prev_value (front_value),
            .next_key   ('0),
            .next_value ('0),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .match      (match_vec[i])
         );
      end else if (i == 0) begin : g_first
         lkv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .lookup_key (req_key),
            .prev_key   (front_key),
            .prev_value (front_value),
            .next_key   (cell_key[i+1]),
            .next_value (cell_value[i+1]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .match      (match_vec[i])
         );
      end else if (i == ENTRIES - 1) begin : g_last
         lkv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .lookup_key (req_key),
            .prev_key   (cell_key[i-1]),
            .prev_value (cell_value[i-1]),
            .next_key   ('0),
            .next_value ('0),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .match      (match_vec[i])
         );
      end else begin : g_mid
         lkv_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[i]),
            .lookup_key (req_key),
            .prev_key   (cell_key[i-1]),
            .prev_value (cell_value[i-1]),
            .next_key   (cell_key[i+1]),
            .next_value (cell_value[i+1]),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .match      (match_vec[i])
         );
      end
   end

   // value of the matching cell (keys are unique among valid cells)
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_value = hit_value | (match_vec[i] ? cell_value[i] : '0);
      end
   end

   // request decode and next state
   always_comb begin
      take_prev   = '0;
      take_next   = '0;
      front_key   = req_key;
      front_value = req_value;
      cap_in      = cap_ff;
      occ_in      = occ_ff;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      evicts_in   = evicts_ff;
      strobe_in   = accept;
      hit_in      = 1'b0;
      rdval_in    = '0;
      if (accept) begin
         case (action)
            ACT_GET: begin
               if (hit_any) begin
                  // promote: newer cells slide one older, hit goes to front
                  hit_in      = 1'b1;
                  rdval_in    = hit_value;
                  hits_in     = sat_add(hits_ff, ONE);
                  take_prev   = up_to_hit;
                  front_value = hit_value;
               end else begin
                  misses_in = sat_add(misses_ff, ONE);
               end
            end
            ACT_PUT: begin
               if (hit_any) begin
                  take_prev = up_to_hit;
               end else if (cap_eff == '0) begin
                  // nothing can be kept: the new key itself is evicted
                  evicts_in = sat_add(evicts_ff, ONE);
               end else begin
                  // insert at front, oldest falls off when full
                  take_prev = '1;
                  if (occ_ff >= cap_eff) begin
                     occ_in    = cap_eff;
                     evicts_in = sat_add(evicts_ff, ONE);
                  end else begin
                     occ_in = occ_ff + ONE;
                  end
               end
            end
            ACT_ERASE: begin
               if (hit_any) begin
                  take_next = at_or_after;
                  occ_in    = occ_ff - ONE;
               end
            end
            default: begin
               occ_in    = '0;
               hits_in   = '0;
               misses_in = '0;
               evicts_in = '0;
            end
         endcase
      end else if (csr_write_en) begin
         // capacity write, trim oldest entries at once
         cap_in = csr_write_data;
         if (occ_ff > new_eff) begin
            occ_in    = new_eff;
            evicts_in = sat_add(evicts_ff, occ_ff - new_eff);
         end
      end
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         cap_ff    <= CAP_RESET;
         occ_ff    <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         cap_ff    <= cap_in;
         occ_ff    <= occ_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      rdval_ff <= rdval_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rdval_ff;
   assign rsp_occupancy   = CAP_BITS'(occ_ff);
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;
   assign rsp_evict_count = evicts_ff;

   // checks
   `LKV_ASSERT_ALWAYS(a_occ_within_cap, occ_ff <= cap_eff, "occupancy above capacity")
   `LKV_ASSERT_ALWAYS(a_unique_match, $onehot0(match_vec), "key matched in more than one cell")
   `LKV_ASSERT_NEXT(a_strobe_follows, accept, strobe_ff, "accepted request gave no response")
   `LKV_ASSERT_SAME(a_miss_reads_zero, strobe_ff && !hit_ff, rdval_ff == '0, "nonzero data without hit")
   `LKV_ASSERT_ALWAYS(a_valid_count, OCC_BITS'($countones(cell_valid)) == occ_ff, "bad valid count")

endmodule

`default_nettype wire

// ----- rtl/lkv_cell.sv -----
// ----------------------------------------------------------------------------
// LRU chain cell
// One recency position: key, value and valid bit, loaded from either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell
   import lkv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [KEY_BITS-1:0]   lookup_key,
   input  wire logic [KEY_BITS-1:0]   prev_key,
   input  wire logic [VALUE_BITS-1:0] prev_value,
   input  wire logic [KEY_BITS-1:0]   next_key,
   input  wire logic [VALUE_BITS-1:0] next_value,
   output logic [KEY_BITS-1:0]        key,
   output logic [VALUE_BITS-1:0]      value,
   output logic                       valid,
   output logic                       match
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  valid_ff;

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid_in;
      end
   end

   // payload shifts toward older or newer positions
   always_ff @(posedge clock) begin
      if (ctrl.take_prev) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end else if (ctrl.take_next) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end
   end

   // key compare
   assign match = valid_ff && (key_ff == lookup_key);
   assign key   = key_ff;
   assign value = value_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get, put, erase and clear requests through the start/busy port and
// checks every reply against a hand-written one or a recency-ordered bench list.
// It sweeps the capacity register across several settings, among them 0 and 31.
// ----------------------------------------------------------------------------
module testbench;
   import lkv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 145;
   localparam int POOL_SIZE        = 24;

   // one reply as seen on the rsp_ ports
   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
      logic [CAP_BITS-1:0]   occupancy;
      logic [CNT_BITS-1:0]   hit_count;
      logic [CNT_BITS-1:0]   miss_count;
      logic [CNT_BITS-1:0]   evict_count;
   } cache_reply_type;

   // one directed step: a capacity write or a request, optionally with a
   // hand-written reply
   typedef struct packed {
      logic                  is_cap_write;
      logic [CAP_BITS-1:0]   new_capacity;
      action_type            act;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] data;
      logic                  typed;
      cache_reply_type       want;
   } plan_step_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] data;
   } cache_line_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_action = ACT_GET;
   logic [KEY_BITS-1:0]   req_key = '0;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic [VALUE_BITS-1:0] rsp_read_value;
   logic [CAP_BITS-1:0]   rsp_occupancy;
   logic [CNT_BITS-1:0]   rsp_hit_count;
   logic [CNT_BITS-1:0]   rsp_miss_count;
   logic [CNT_BITS-1:0]   rsp_evict_count;
   logic                  csr_write_en = 1'b0;
   logic [CAP_BITS-1:0]   csr_write_data = '0;

   // bench copy of the cache: index 0 is the most recent line
   cache_line_type      recency_list [$];
   logic [CNT_BITS-1:0] hits_seen;
   logic [CNT_BITS-1:0] misses_seen;
   logic [CNT_BITS-1:0] evictions_seen;
   logic [CAP_BITS-1:0] capacity_setting;

   cache_reply_type     pending_replies [$];
   int                  mismatch_total = 0;
   int                  requests_sent  = 0;

   lru_key_value_cache DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .rsp_evict_count (rsp_evict_count),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CNT_BITS-1:0] bump(input logic [CNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // slots limit the store whatever the register says
   function automatic int line_limit();
      return (int'(capacity_setting) > ENTRIES) ? ENTRIES : int'(capacity_setting);
   endfunction

   // drop least recent lines until at most 'limit' remain
   task automatic trim_to(input int limit);
      while (recency_list.size() > limit) begin
         recency_list.delete(recency_list.size() - 1);
         evictions_seen = bump(evictions_seen);
      end
   endtask

   task automatic set_capacity_model(input logic [CAP_BITS-1:0] cap);
      capacity_setting = cap;
      trim_to(line_limit());
   endtask

   // advance the bench copy by one request and form its reply
   task automatic predict_cache_reply(input action_type act,
                                      input logic [KEY_BITS-1:0] k,
                                      input logic [VALUE_BITS-1:0] v,
                                      output cache_reply_type reply);
      int             slot;
      cache_line_type line;
      slot  = -1;
      reply = '0;
      foreach (recency_list[i])
         if (slot < 0 && recency_list[i].key == k) slot = i;

      case (act)
         ACT_GET: begin
            if (slot >= 0) begin
               line = recency_list[slot];
               reply.hit        = 1'b1;
               reply.read_value = line.data;
               hits_seen        = bump(hits_seen);
               recency_list.delete(slot);
               recency_list.insert(0, line);
            end else begin
               misses_seen = bump(misses_seen);
            end
         end
         ACT_PUT: begin
            if (slot >= 0) begin
               line      = recency_list[slot];
               line.data = v;
               recency_list.delete(slot);
               recency_list.insert(0, line);
            end else if (line_limit() == 0) begin
               // nothing can be kept: the new key itself counts as evicted
               trim_to(0);
               evictions_seen = bump(evictions_seen);
            end else begin
               trim_to(line_limit() - 1);
               line.key  = k;
               line.data = v;
               recency_list.insert(0, line);
            end
         end
         ACT_ERASE: begin
            if (slot >= 0) recency_list.delete(slot);
         end
         default: begin
            recency_list.delete();
            hits_seen      = '0;
            misses_seen    = '0;
            evictions_seen = '0;
         end
      endcase

      reply.occupancy   = CAP_BITS'(recency_list.size());
      reply.hit_count   = hits_seen;
      reply.miss_count  = misses_seen;
      reply.evict_count = evictions_seen;
   endtask

   function automatic cache_reply_type reply(input logic h, input logic [31:0] rd,
                                             input int occ, input int hc,
                                             input int mc, input int ec);
      cache_reply_type r;
      r.hit         = h;
      r.read_value  = rd;
      r.occupancy   = CAP_BITS'(occ);
      r.hit_count   = CNT_BITS'(hc);
      r.miss_count  = CNT_BITS'(mc);
      r.evict_count = CNT_BITS'(ec);
      return r;
   endfunction

   function automatic plan_step_type cap_row(input int cap);
      plan_step_type s;
      s              = '0;
      s.is_cap_write = 1'b1;
      s.new_capacity = CAP_BITS'(cap);
      s.act          = ACT_GET;
      return s;
   endfunction

   function automatic plan_step_type req_row(input action_type act,
                                             input logic [31:0] k,
                                             input logic [31:0] v);
      plan_step_type s;
      s      = '0;
      s.act  = act;
      s.key  = k;
      s.data = v;
      return s;
   endfunction

   function automatic plan_step_type known_row(input action_type act,
                                               input logic [31:0] k,
                                               input logic [31:0] v,
                                               input cache_reply_type want);
      plan_step_type s;
      s       = req_row(act, k, v);
      s.typed = 1'b1;
      s.want  = want;
      return s;
   endfunction

   // present one request and hold it until taken
   task automatic issue_request(input action_type act, input logic [KEY_BITS-1:0] k,
                                input logic [VALUE_BITS-1:0] v, input logic typed,
                                input cache_reply_type want);
      cache_reply_type predicted;
      start      <= 1'b1;
      req_action <= act;
      req_key    <= k;
      req_value  <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_cache_reply(act, k, v, predicted);
      pending_replies.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // random sender gaps, none inside the quiet window
   task automatic maybe_pause();
      if ((requests_sent < 500 || requests_sent >= 800) && $urandom_range(0, 99) < 14) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // register writes only once every reply is back
   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_en <= 1'b0;
      set_capacity_model(cap);
   endtask

   // reply check
   always @(posedge clock) begin : reply_check
      cache_reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding");
            mismatch_total++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
               mismatch_total++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               mismatch_total++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_occupancy);
               mismatch_total++;
            end
            if (rsp_hit_count !== want.hit_count) begin
               $error("hit_count: expected %0d, got %0d", want.hit_count, rsp_hit_count);
               mismatch_total++;
            end
            if (rsp_miss_count !== want.miss_count) begin
               $error("miss_count: expected %0d, got %0d", want.miss_count, rsp_miss_count);
               mismatch_total++;
            end
            if (rsp_evict_count !== want.evict_count) begin
               $error("evict_count: expected %0d, got %0d",
                      want.evict_count, rsp_evict_count);
               mismatch_total++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      plan_step_type       directed_plan [28];
      logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
      logic [CAP_BITS-1:0] phase_caps [10];
      logic [KEY_BITS-1:0] k;
      action_type          act;
      int                  pick;

      // directed walk: empty store, key and value extremes, update in place,
      // absent erase, clear, eviction order, capacity zero, capacity above
      // the slot count and a capacity drop with lines present
      directed_plan = '{
         known_row(ACT_GET,   32'h0,        32'hDEADBEEF, reply(0, 32'h0,        0, 0, 1, 0)),
         known_row(ACT_PUT,   32'h0,        32'h0,        reply(0, 32'h0,        1, 0, 1, 0)),
         known_row(ACT_PUT,   32'hFFFFFFFF, 32'hFFFFFFFF, reply(0, 32'h0,        2, 0, 1, 0)),
         known_row(ACT_GET,   32'hFFFFFFFF, 32'h0,        reply(1, 32'hFFFFFFFF, 2, 1, 1, 0)),
         known_row(ACT_GET,   32'h0,        32'hFFFFFFFF, reply(1, 32'h0,        2, 2, 1, 0)),
         known_row(ACT_PUT,   32'h0,        32'hA5A55A5A, reply(0, 32'h0,        2, 2, 1, 0)),
         known_row(ACT_GET,   32'h0,        32'h0,        reply(1, 32'hA5A55A5A, 2, 3, 1, 0)),
         known_row(ACT_ERASE, 32'h12345678, 32'h77777777, reply(0, 32'h0,        2, 3, 1, 0)),
         known_row(ACT_ERASE, 32'hFFFFFFFF, 32'h0,        reply(0, 32'h0,        1, 3, 1, 0)),
         known_row(ACT_GET,   32'hFFFFFFFF, 32'h0,        reply(0, 32'h0,        1, 3, 2, 0)),
         known_row(ACT_CLEAR, 32'h5A5A5A5A, 32'hFFFFFFFF, reply(0, 32'h0,        0, 0, 0, 0)),
         cap_row(2),
         known_row(ACT_PUT,   32'h1,        32'h11,       reply(0, 32'h0,        1, 0, 0, 0)),
         known_row(ACT_PUT,   32'h2,        32'h22,       reply(0, 32'h0,        2, 0, 0, 0)),
         known_row(ACT_GET,   32'h1,        32'h0,        reply(1, 32'h11,       2, 1, 0, 0)),
         known_row(ACT_PUT,   32'h3,        32'h33,       reply(0, 32'h0,        2, 1, 0, 1)),
         known_row(ACT_GET,   32'h2,        32'h0,        reply(0, 32'h0,        2, 1, 1, 1)),
         known_row(ACT_GET,   32'h1,        32'h0,        reply(1, 32'h11,       2, 2, 1, 1)),
         cap_row(0),
         known_row(ACT_PUT,   32'h4,        32'h44,       reply(0, 32'h0,        0, 2, 1, 4)),
         known_row(ACT_GET,   32'h4,        32'h0,        reply(0, 32'h0,        0, 2, 2, 4)),
         cap_row(31),
         req_row(ACT_PUT, 32'h5, 32'h55),
         req_row(ACT_PUT, 32'h6, 32'h66),
         req_row(ACT_GET, 32'h5, 32'h0),
         cap_row(1),
         req_row(ACT_GET, 32'h6, 32'h0),
         req_row(ACT_GET, 32'h5, 32'h0)
      };
      phase_caps = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd0, 5'd3, 5'd17, 5'd12, 5'd2, 5'd16};

      recency_list.delete();
      hits_seen      = '0;
      misses_seen    = '0;
      evictions_seen = '0;
      capacity_setting = CAP_RESET;

      // small key set so that gets hit and puts collide; both extremes in it
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cap_write) begin
            write_capacity(directed_plan[i].new_capacity);
         end else begin
            maybe_pause();
            issue_request(directed_plan[i].act, directed_plan[i].key, directed_plan[i].data,
                          directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // random phases, one capacity setting each
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      act = ACT_GET;
            else if (pick < 85) act = ACT_PUT;
            else if (pick < 97) act = ACT_ERASE;
            else                act = ACT_CLEAR;
            if ($urandom_range(0, 9) == 0) k = $urandom();
            else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            maybe_pause();
            issue_request(act, k, $urandom(), 1'b0, '0);
         end
      end

      // drain
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_total == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
